// ===== rtl/bbr_pkg.sv =====
package bbr_pkg;

    localparam int MAX_KERNEL = 15;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int RING_ROWS  = MAX_KERNEL + 1;
    localparam int RING_BITS  = $clog2(RING_ROWS);
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int MEM_DEPTH  = RING_ROWS * MAX_WIDTH;
    localparam int ADDR_BITS  = $clog2(MEM_DEPTH);

    localparam logic [1:0] REG_KERNEL = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam int NUM_BITS = 17;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_LAST = 6'b000100,
        S_PREP = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    // reflect-101 about the frame edges, v never more than one kernel outside
    function automatic logic [10:0] mirror(input logic signed [12:0] v, input logic [10:0] n);
        logic signed [13:0] a;
        logic signed [13:0] nn;
        begin
            nn = {3'b000, n};
            a  = (v < 0) ? -{v[12], v} : {v[12], v};
            if (a >= nn) begin
                a = 14'(2 * nn - 14'sd2 - a);
            end
            mirror = a[10:0];
        end
    endfunction

endpackage

// ===== rtl/box_blur_reflect101.sv =====
// box_blur_reflect101: kxk mean blur of an 8-bit grayscale raster stream with
// a reflect-101 border.
// input channel s_*: one beat per pixel (s_cmd = pixel) or drain tick
// (s_cmd = drain) after the frame. output channel m_*: zero or one result
// beat per input beat, in order.
// configuration through the apb port: 0x0 kernel_size, 0x4 frame_width,
// 0x8 frame_height. a write to any of these three restarts the frame position.
// a pixel that causes no result does not make the block busy. a result
// takes k*k reads of the line store, one per cycle through its single
// read port, then a 17-step restoring divide. a rejected pixel goes to
// the output register as a rejected beat. one item is worked on at a time;
// the next is taken once the current result sits in the output register.
// reset (synchronous, aresetn low) clears position counters and control
// state, loads kernel 3, 640x480; the line store is not cleared.
// when the receiver stalls the result holds in the output register and
// the block stops taking input once its next result is also ready.
module box_blur_reflect101 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_pixel_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_blurred_pixel,
    output logic        m_frame_end,
    output logic        m_rejected,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bbr_pkg::state_t state_reg, state_next;

    logic [3:0]  ksize_reg;
    logic [10:0] fwidth_reg;
    logic [10:0] fheight_reg;

    logic [10:0] in_row_reg;
    logic [9:0]  in_col_reg;
    logic [19:0] in_index_reg;
    logic [19:0] out_pos_reg;
    logic [10:0] out_row_reg;
    logic [9:0]  out_col_reg;

    logic [10:0] wr_row_reg;
    logic [9:0]  wr_col_reg;
    logic        wr_end_reg;
    logic        wr_rej_reg;
    logic [3:0]  dy_reg;
    logic [3:0]  dx_reg;
    logic        rd_pend_reg;
    logic [15:0] sum_reg;
    logic [16:0] num_reg;
    logic [9:0]  rem_reg;
    logic [16:0] quot_reg;
    logic [4:0]  div_cnt_reg;

    logic        m_valid_reg;
    logic [7:0]  m_pix_reg;
    logic        m_end_reg;
    logic        m_rej_reg;

    logic [7:0]  store_mem [bbr_pkg::MEM_DEPTH];
    logic [7:0]  rdata_reg;
    logic [bbr_pkg::ADDR_BITS-1:0] raddr;

    logic        cfg_wr;
    logic [2:0]  half;
    logic        cfg_ok;
    logic [21:0] total;
    logic [19:0] delay;
    logic [7:0]  area;
    logic [8:0]  divisor;
    logic        accept;
    logic        is_pix;
    logic        do_emit;
    logic        frame_in;
    logic        wrap;
    logic [10:0] mrow;
    logic [10:0] mcol;
    logic [10:0] trial;
    logic        last_rd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            bbr_pkg::REG_KERNEL: prdata = {28'd0, ksize_reg};
            bbr_pkg::REG_WIDTH:  prdata = {21'd0, fwidth_reg};
            bbr_pkg::REG_HEIGHT: prdata = {21'd0, fheight_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign half    = ksize_reg[3:1];
    assign cfg_ok  = ksize_reg[0]
                     && (fwidth_reg <= 11'(bbr_pkg::MAX_WIDTH))
                     && (fheight_reg <= 11'(bbr_pkg::MAX_HEIGHT))
                     && ({8'd0, half} < fwidth_reg) && ({8'd0, half} < fheight_reg);
    assign total   = fwidth_reg * fheight_reg;
    assign delay   = ({17'd0, half} * {9'd0, fwidth_reg}) + {17'd0, half};
    assign area    = ksize_reg * ksize_reg;
    assign divisor = {area, 1'b0};

    assign s_ready  = (state_reg == bbr_pkg::S_IDLE);
    assign accept   = s_valid && s_ready;
    assign frame_in = (in_row_reg >= fheight_reg);
    assign is_pix   = (s_cmd == bbr_pkg::CMD_PIXEL);
    always_comb begin
        if (is_pix) begin
            do_emit = !frame_in && (in_index_reg >= delay);
        end else begin
            do_emit = frame_in && ({2'b00, out_pos_reg} < total);
        end
    end
    assign wrap = ({2'b00, out_pos_reg} + 22'd1 >= total);

    // window taps, mirrored at the frame edges
    assign mrow = bbr_pkg::mirror(13'($signed({2'b00, wr_row_reg}) + $signed({9'd0, dy_reg})
                                  - $signed({10'd0, half})), fheight_reg);
    assign mcol = bbr_pkg::mirror(13'($signed({3'b000, wr_col_reg}) + $signed({9'd0, dx_reg})
                                  - $signed({10'd0, half})), fwidth_reg);
    assign raddr = {mrow[bbr_pkg::RING_BITS-1:0], mcol[bbr_pkg::COL_BITS-1:0]};
    assign last_rd = (dy_reg == ksize_reg - 4'd1) && (dx_reg == ksize_reg - 4'd1);

    always_ff @(posedge aclk) begin
        if (accept && cfg_ok && is_pix && !frame_in) begin
            store_mem[{in_row_reg[bbr_pkg::RING_BITS-1:0], in_col_reg}] <= s_pixel_in;
        end
        rdata_reg <= store_mem[raddr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bbr_pkg::S_IDLE: begin
                if (accept) begin
                    if (!cfg_ok) begin
                        state_next = is_pix ? bbr_pkg::S_DONE : bbr_pkg::S_IDLE;
                    end else if (do_emit) begin
                        state_next = bbr_pkg::S_READ;
                    end
                end
            end
            bbr_pkg::S_READ: if (last_rd) state_next = bbr_pkg::S_LAST;
            bbr_pkg::S_LAST: state_next = bbr_pkg::S_PREP;
            bbr_pkg::S_PREP: state_next = bbr_pkg::S_DIV;
            bbr_pkg::S_DIV: begin
                if (div_cnt_reg == 5'(bbr_pkg::NUM_BITS - 1)) state_next = bbr_pkg::S_DONE;
            end
            bbr_pkg::S_DONE: if (!m_valid_reg || m_ready) state_next = bbr_pkg::S_IDLE;
            default: state_next = bbr_pkg::S_IDLE;
        endcase
    end

    assign trial = {rem_reg, num_reg[bbr_pkg::NUM_BITS-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bbr_pkg::S_IDLE;
            ksize_reg    <= 4'd3;
            fwidth_reg   <= 11'd640;
            fheight_reg  <= 11'd480;
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_index_reg <= '0;
            out_pos_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == bbr_pkg::S_READ);
            if (state_reg == bbr_pkg::S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr && (paddr[3:2] inside {bbr_pkg::REG_KERNEL, bbr_pkg::REG_WIDTH,
                                              bbr_pkg::REG_HEIGHT})) begin
                case (paddr[3:2])
                    bbr_pkg::REG_KERNEL: ksize_reg   <= pwdata[3:0];
                    bbr_pkg::REG_WIDTH:  fwidth_reg  <= pwdata[10:0];
                    bbr_pkg::REG_HEIGHT: fheight_reg <= pwdata[10:0];
                    default: ;
                endcase
                in_row_reg   <= '0;
                in_col_reg   <= '0;
                in_index_reg <= '0;
                out_pos_reg  <= '0;
                out_row_reg  <= '0;
                out_col_reg  <= '0;
            end else if (accept && cfg_ok) begin
                if (do_emit && wrap) begin
                    out_pos_reg  <= '0;
                    out_row_reg  <= '0;
                    out_col_reg  <= '0;
                    in_row_reg   <= '0;
                    in_col_reg   <= '0;
                    in_index_reg <= '0;
                end else begin
                    if (is_pix && !frame_in) begin
                        in_index_reg <= in_index_reg + 20'd1;
                        if ({1'b0, in_col_reg} + 11'd1 >= fwidth_reg) begin
                            in_col_reg <= '0;
                            in_row_reg <= in_row_reg + 11'd1;
                        end else begin
                            in_col_reg <= in_col_reg + 10'd1;
                        end
                    end
                    if (do_emit) begin
                        out_pos_reg <= out_pos_reg + 20'd1;
                        if ({1'b0, out_col_reg} + 11'd1 >= fwidth_reg) begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + 11'd1;
                        end else begin
                            out_col_reg <= out_col_reg + 10'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            wr_row_reg <= out_row_reg;
            wr_col_reg <= out_col_reg;
            wr_end_reg <= wrap;
            wr_rej_reg <= !cfg_ok;
            dy_reg     <= '0;
            dx_reg     <= '0;
            sum_reg    <= '0;
        end
        if (state_reg == bbr_pkg::S_READ) begin
            if (dx_reg == ksize_reg - 4'd1) begin
                dx_reg <= '0;
                dy_reg <= dy_reg + 4'd1;
            end else begin
                dx_reg <= dx_reg + 4'd1;
            end
        end
        if (rd_pend_reg) sum_reg <= sum_reg + {8'd0, rdata_reg};
        // rounded mean: (2*sum + area) / (2*area), one quotient bit a cycle
        if (state_reg == bbr_pkg::S_PREP) begin
            num_reg     <= {sum_reg, 1'b0} + {9'd0, area};
            rem_reg     <= '0;
            quot_reg    <= '0;
            div_cnt_reg <= '0;
        end
        if (state_reg == bbr_pkg::S_DIV) begin
            num_reg     <= {num_reg[bbr_pkg::NUM_BITS-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + 5'd1;
            if (trial >= {2'b00, divisor}) begin
                rem_reg  <= 10'(trial - {2'b00, divisor});
                quot_reg <= {quot_reg[bbr_pkg::NUM_BITS-2:0], 1'b1};
            end else begin
                rem_reg  <= trial[9:0];
                quot_reg <= {quot_reg[bbr_pkg::NUM_BITS-2:0], 1'b0};
            end
        end
        if (state_reg == bbr_pkg::S_DONE && (!m_valid_reg || m_ready)) begin
            m_pix_reg <= wr_rej_reg ? 8'd0 : quot_reg[7:0];
            m_end_reg <= wr_rej_reg ? 1'b0 : wr_end_reg;
            m_rej_reg <= wr_rej_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_blurred_pixel = m_pix_reg;
    assign m_frame_end     = m_end_reg;
    assign m_rejected      = m_rej_reg;

    a_read_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bbr_pkg::S_READ) |-> (dy_reg < ksize_reg && dx_reg < ksize_reg))
        else $error("window tap beyond kernel");

    a_pend_src: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> $past(state_reg == bbr_pkg::S_READ))
        else $error("store read data without a read");

    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bbr_pkg::S_DIV) |=>
            (state_reg == bbr_pkg::S_DIV || state_reg == bbr_pkg::S_DONE))
        else $error("divide left early");

endmodule
